FILE: hdl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// shared types, codes and helpers for the bezier curve evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam logic [16:0] T_ONE = 17'd65536;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_POS   = 2'd1,
        OP_TAN   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic KIND_POS = 1'b0;
    localparam logic KIND_TAN = 1'b1;

    typedef struct packed {
        opcode_t             opcode;
        logic [3:0]          point_index;
        logic signed [31:0]  point_x;
        logic signed [31:0]  point_y;
        logic signed [31:0]  point_z;
        logic [16:0]         t_param;
    } req_t;

    typedef struct packed {
        logic                result_kind;
        logic signed [31:0]  res_x;
        logic signed [31:0]  res_y;
        logic signed [31:0]  res_z;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  z;
    } point_t;

    // working coordinate: one bit above q16.16 so point differences fit
    typedef logic signed [32:0] wcoord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LERP,
        ST_PICK,
        ST_NORM,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // operands of the shared multiplier
    typedef struct packed {
        logic        is_square;
        wcoord_t     a;
        wcoord_t     b;
        logic [16:0] t;
        logic [30:0] m;
    } mul_op_t;

    // command to the root / divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] arg;
        logic [32:0] den;
    } ru_cmd_t;

    function automatic logic signed [31:0] sat32(input wcoord_t v);
        logic signed [31:0] r;
        begin
            if (v > 33'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (v < -33'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// bezier_curve_evaluator
// 3-d bezier position and unit tangent from a store of control points
// ----------------------------------------------------------------------------
// Control points are written one per transfer (opcode 0). A position
// request walks the de Casteljau recurrence on one shared multiplier, one
// coordinate per cycle: it loads the n points, runs the multiply steps with
// a reorder step at the end of each level, then picks and outputs the
// result. A tangent request runs the same recurrence on the n-1 point
// differences, then normalizes the vector with a one-bit-per-cycle shifter,
// forms the squared length on the multiplier, takes the root and divides
// each coordinate on the shared bit-serial root/divide unit. Requests are
// taken one at a time; the next request is accepted while a finished result
// still waits in the output register. Slots never written read back
// undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_evaluator #(
    parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cfg_valid,
    output logic           cfg_ready,
    input  wire [4:0]      cfg_data,
    input  wire            req_valid,
    output logic           req_ready,
    input  bce_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  wire            rsp_ready,
    output bce_pkg::rsp_t  rsp_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // control state
    bce_pkg::state_t state_reg, state_next;
    logic [4:0]      count_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   step_reg;
    logic [CW-1:0]   rd_cnt_reg;
    logic [CW-1:0]   ld_cnt_reg;
    logic            rvalid_reg;
    logic [1:0]      comp_reg;
    logic            tan_reg;
    logic            rsp_valid_reg;

    // payload
    bce_pkg::wcoord_t    q_reg [MAX_POINTS][3];
    bce_pkg::wcoord_t    new_reg [2];
    bce_pkg::point_t     prev_reg;
    logic [16:0]         t_reg;
    logic [32:0]         mag_reg [3];
    logic                neg_reg [3];
    logic [63:0]         sum_reg;
    logic [32:0]         len_reg;
    logic signed [31:0]  res_reg [3];
    bce_pkg::rsp_t       rsp_reg;

    // memory, shared units
    bce_pkg::point_t  rd_data;
    logic             wr_en;
    logic             rd_issue;
    bce_pkg::mul_op_t mul_op;
    bce_pkg::wcoord_t lerp_res;
    logic [63:0]      sq_res;
    bce_pkg::ru_cmd_t ru_cmd;
    logic             ru_done;
    logic [63:0]      ru_result;

    // decode helpers
    logic            req_acc;
    logic            is_eval;
    logic            is_tan_req;
    logic [CW-1:0]   n_eff;
    logic            degenerate;
    logic            ld_last;
    logic            drop;
    logic [32:0]     mx;
    logic            out_free;
    logic [47:0]     num;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == bce_pkg::ST_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        is_tan_req = (req_data.opcode == bce_pkg::OP_TAN);
        is_eval    = (req_data.opcode == bce_pkg::OP_POS) || is_tan_req;
        n_eff      = (32'(count_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_reg);
        degenerate = is_tan_req ? (n_eff < CW'(2)) : (n_eff == '0);
        wr_en      = req_acc && (req_data.opcode == bce_pkg::OP_WRITE)
                     && (32'(req_data.point_index) < 32'(MAX_POINTS));
        rd_issue   = (state_reg == bce_pkg::ST_LOAD) && (rd_cnt_reg < n_reg);
        ld_last    = rvalid_reg && (ld_cnt_reg == CW'(n_reg - 1'b1));
        drop       = (step_reg == CW'(k_reg - 1'b1));
        mx         = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
        num = 48'({mag_reg[comp_reg][30:0], 16'd0}) + 48'(len_reg >> 1);
    end

    bce_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(req_data.point_index)),
        .wr_data ({req_data.point_x, req_data.point_y, req_data.point_z}),
        .rd_en   (rd_issue),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // one multiplier serves interpolation steps and the squared length
    always_comb
    begin
        mul_op.is_square = (state_reg == bce_pkg::ST_SQUARE);
        mul_op.a         = q_reg[0][comp_reg];
        mul_op.b         = q_reg[1][comp_reg];
        mul_op.t         = t_reg;
        mul_op.m         = mag_reg[comp_reg][30:0];
    end

    bce_mul_unit u_mul (
        .op       (mul_op),
        .lerp_res (lerp_res),
        .sq_res   (sq_res)
    );

    always_comb
    begin
        ru_cmd.start  = 1'b0;
        ru_cmd.is_div = 1'b0;
        ru_cmd.arg    = sum_reg + sq_res;
        ru_cmd.den    = len_reg;
        if (state_reg == bce_pkg::ST_SQUARE && comp_reg == 2'd2)
        begin
            ru_cmd.start = 1'b1;
        end
        else if (state_reg == bce_pkg::ST_DIV_GO)
        begin
            ru_cmd.start  = 1'b1;
            ru_cmd.is_div = 1'b1;
            ru_cmd.arg    = 64'(num);
        end
    end

    bce_root_div u_root_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ru_cmd),
        .done   (ru_done),
        .result (ru_result)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                if (req_acc && is_eval)
                begin
                    state_next = degenerate ? bce_pkg::ST_OUT : bce_pkg::ST_LOAD;
                end
            end
            bce_pkg::ST_LOAD:
            begin
                if (ld_last)
                begin
                    state_next = (k_reg == CW'(1)) ? bce_pkg::ST_PICK : bce_pkg::ST_LERP;
                end
            end
            bce_pkg::ST_LERP:
            begin
                if (drop && k_reg == CW'(2))
                begin
                    state_next = bce_pkg::ST_PICK;
                end
            end
            bce_pkg::ST_PICK:
            begin
                state_next = tan_reg ? bce_pkg::ST_NORM : bce_pkg::ST_OUT;
            end
            bce_pkg::ST_NORM:
            begin
                if (mx == '0)
                begin
                    state_next = bce_pkg::ST_OUT;
                end
                else if (mx[32:31] == 2'b00 && mx[30])
                begin
                    state_next = bce_pkg::ST_SQUARE;
                end
            end
            bce_pkg::ST_SQUARE:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = bce_pkg::ST_ROOT;
                end
            end
            bce_pkg::ST_ROOT:
            begin
                if (ru_done)
                begin
                    state_next = bce_pkg::ST_DIV_GO;
                end
            end
            bce_pkg::ST_DIV_GO:
            begin
                state_next = bce_pkg::ST_DIV_WAIT;
            end
            bce_pkg::ST_DIV_WAIT:
            begin
                if (ru_done)
                begin
                    state_next = (comp_reg == 2'd2) ? bce_pkg::ST_OUT : bce_pkg::ST_DIV_GO;
                end
            end
            bce_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = bce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bce_pkg::ST_IDLE;
            end
        endcase
    end

    // counters and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            rd_cnt_reg    <= '0;
            ld_cnt_reg    <= '0;
            rvalid_reg    <= 1'b0;
            comp_reg      <= '0;
            tan_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            if (state_reg == bce_pkg::ST_OUT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                bce_pkg::ST_IDLE:
                begin
                    n_reg      <= n_eff;
                    k_reg      <= is_tan_req ? CW'(n_eff - 1'b1) : n_eff;
                    tan_reg    <= is_tan_req;
                    rd_cnt_reg <= '0;
                    ld_cnt_reg <= '0;
                    rvalid_reg <= 1'b0;
                    step_reg   <= '0;
                    comp_reg   <= '0;
                end
                bce_pkg::ST_LOAD:
                begin
                    rvalid_reg <= rd_issue;
                    if (rd_issue)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (rvalid_reg)
                    begin
                        ld_cnt_reg <= ld_cnt_reg + 1'b1;
                    end
                end
                bce_pkg::ST_LERP:
                begin
                    if (drop)
                    begin
                        k_reg    <= k_reg - 1'b1;
                        step_reg <= '0;
                    end
                    else if (comp_reg == 2'd2)
                    begin
                        comp_reg <= '0;
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                bce_pkg::ST_SQUARE:
                begin
                    comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                end
                bce_pkg::ST_DIV_WAIT:
                begin
                    if (ru_done)
                    begin
                        comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                t_reg <= (req_data.t_param > bce_pkg::T_ONE) ? bce_pkg::T_ONE
                                                             : req_data.t_param;
                for (int c = 0; c < 3; c++)
                begin
                    res_reg[c] <= '0;
                end
            end
            bce_pkg::ST_LOAD:
            begin
                if (rvalid_reg)
                begin
                    prev_reg <= rd_data;
                    if (!tan_reg)
                    begin
                        q_reg[ld_cnt_reg[AW-1:0]][0] <= 33'(rd_data.x);
                        q_reg[ld_cnt_reg[AW-1:0]][1] <= 33'(rd_data.y);
                        q_reg[ld_cnt_reg[AW-1:0]][2] <= 33'(rd_data.z);
                    end
                    else if (ld_cnt_reg != '0)
                    begin
                        // keep the file's sign: earlier point minus later one
                        q_reg[AW'(ld_cnt_reg - 1'b1)][0] <= 33'(prev_reg.x) - 33'(rd_data.x);
                        q_reg[AW'(ld_cnt_reg - 1'b1)][1] <= 33'(prev_reg.y) - 33'(rd_data.y);
                        q_reg[AW'(ld_cnt_reg - 1'b1)][2] <= 33'(prev_reg.z) - 33'(rd_data.z);
                    end
                end
            end
            bce_pkg::ST_LERP:
            begin
                // front pair feeds the multiplier; results rejoin at the tail
                if (drop || comp_reg == 2'd2)
                begin
                    for (int i = 0; i < MAX_POINTS; i++)
                    begin
                        if (!drop && i == int'(k_reg) - 1)
                        begin
                            q_reg[i][0] <= new_reg[0];
                            q_reg[i][1] <= new_reg[1];
                            q_reg[i][2] <= lerp_res;
                        end
                        else
                        begin
                            // the last slot lies past the live entries
                            q_reg[i] <= q_reg[(i + 1) % MAX_POINTS];
                        end
                    end
                end
                else
                begin
                    new_reg[comp_reg[0]] <= lerp_res;
                end
            end
            bce_pkg::ST_PICK:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    res_reg[c] <= bce_pkg::sat32(q_reg[0][c]);
                    neg_reg[c] <= q_reg[0][c] < 0;
                    mag_reg[c] <= (q_reg[0][c] < 0) ? 33'(-q_reg[0][c]) : q_reg[0][c];
                end
            end
            bce_pkg::ST_NORM:
            begin
                sum_reg <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    res_reg[c] <= '0;
                    if (mx[32:31] != 2'b00)
                    begin
                        mag_reg[c] <= mag_reg[c] >> 1;
                    end
                    else if (!mx[30])
                    begin
                        mag_reg[c] <= mag_reg[c] << 1;
                    end
                end
            end
            bce_pkg::ST_SQUARE:
            begin
                sum_reg <= sum_reg + sq_res;
            end
            bce_pkg::ST_ROOT:
            begin
                if (ru_done)
                begin
                    len_reg <= ru_result[32:0];
                end
            end
            bce_pkg::ST_DIV_WAIT:
            begin
                if (ru_done)
                begin
                    res_reg[comp_reg] <= neg_reg[comp_reg] ? -ru_result[31:0]
                                                           : ru_result[31:0];
                end
            end
            bce_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    rsp_reg.result_kind <= tan_reg ? bce_pkg::KIND_TAN : bce_pkg::KIND_POS;
                    rsp_reg.res_x       <= res_reg[0];
                    rsp_reg.res_y       <= res_reg[1];
                    rsp_reg.res_z       <= res_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/bce_point_mem.sv
// ----------------------------------------------------------------------------
// bce_point_mem
// control point store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bce_point_mem #(
    parameter int DEPTH = bce_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                   clk,
    input  wire                   wr_en,
    input  wire [AW-1:0]          wr_addr,
    input  bce_pkg::point_t       wr_data,
    input  wire                   rd_en,
    input  wire [AW-1:0]          rd_addr,
    output bce_pkg::point_t       rd_data
);

    bce_pkg::point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bce_mul_unit.sv
// ----------------------------------------------------------------------------
// bce_mul_unit
// shared multiplier: rounded interpolation step or squared magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module bce_mul_unit (
    input  bce_pkg::mul_op_t  op,
    output bce_pkg::wcoord_t  lerp_res,
    output logic [63:0]       sq_res
);

    logic signed [33:0] diff;
    logic signed [33:0] opa;
    logic signed [31:0] opb;
    logic signed [65:0] prod;
    logic signed [51:0] rnd;
    logic signed [35:0] shf;
    logic signed [35:0] sum;

    always_comb
    begin
        diff = 34'(op.b) - 34'(op.a);
        opa  = op.is_square ? $signed({3'b000, op.m}) : diff;
        opb  = op.is_square ? $signed({1'b0, op.m}) : $signed({15'd0, op.t});
        prod = opa * opb;
        // round half up, then floor by the q1.16 scale
        rnd  = $signed(prod[51:0]) + 52'sd32768;
        shf  = 36'(rnd >>> 16);
        sum  = 36'(op.a) + shf;
    end

    assign lerp_res = sum[32:0];
    assign sq_res   = prod[63:0];

endmodule

`default_nettype wire

FILE: hdl/bce_root_div.sv
// ----------------------------------------------------------------------------
// bce_root_div
// bit-serial integer square root and restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bce_root_div (
    input  wire               clk,
    input  wire               rst_n,
    input  bce_pkg::ru_cmd_t  cmd,
    output logic              done,
    output logic [63:0]       result
);

    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS  = 6'd48;

    logic        busy_reg;
    logic        mode_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [32:0] den_reg;

    logic [63:0] trial;
    logic [33:0] rs;
    logic        ge;

    always_comb
    begin
        trial = res_reg + bit_reg;
        rs    = {res_reg[32:0], x_reg[47]};
        ge    = rs >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.is_div;
                cnt_reg  <= cmd.is_div ? DIV_STEPS : SQRT_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= cmd.arg;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
            den_reg <= cmd.den;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                res_reg <= 64'(ge ? rs - {1'b0, den_reg} : rs);
                x_reg   <= {16'd0, x_reg[46:0], ge};
            end
            else
            begin
                if (x_reg >= trial)
                begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign done   = done_reg;
    assign result = mode_reg ? x_reg : res_reg;

endmodule

`default_nettype wire

FILE: hdl/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// port-level checks of the bezier curve evaluator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bce_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            cfg_valid,
    input wire            cfg_ready,
    input wire [4:0]      cfg_data,
    input wire            req_valid,
    input wire            req_ready,
    input bce_pkg::req_t  req_data,
    input wire            rsp_valid,
    input wire            rsp_ready,
    input bce_pkg::rsp_t  rsp_data
);

    // a waiting result holds until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped or changed while stalled");

    // a point write never blocks the next request
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.opcode == bce_pkg::OP_WRITE |=> req_ready)
        else $error("not ready after point write");

    // an evaluate request occupies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.opcode == bce_pkg::OP_POS
            || req_data.opcode == bce_pkg::OP_TAN) |=> !req_ready)
        else $error("ready right after evaluate request");

    // no result appears without a request in flight the cycle before
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result raised while idle");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready || !cfg_valid)
        else $error("configuration write refused");

endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (.*);

`default_nettype wire
